/* rtl/lvrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrc_pkg: low voltage relay cutoff shared types and constants
// Word layouts, rule fields, register indexes and the timer add.
// ----------------------------------------------------------------------------
package lvrc_pkg;

	localparam int RULE_COUNT  = 4;
	localparam int RELAY_COUNT = 8;
	localparam int SLOTS       = 4;

	localparam int MV_W        = 16;
	localparam int DT_W        = 16;
	localparam int RELAY_W     = 8;
	localparam int RELAY_IDX_W = $clog2(RELAY_W);
	localparam int NUM_W       = 4;
	localparam int TIMER_W     = 24;
	localparam int RULE_W      = 60;
	localparam int CFG_W       = 60;
	localparam int CFG_IDX_W   = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RULE0  = CFG_IDX_W'(1);

	typedef struct packed {
		logic [TIMER_W-1:0] confirm_ms;
		logic [MV_W-1:0]    restore_mv;
		logic [MV_W-1:0]    cut_mv;
		logic [NUM_W-1:0]   relay_num;
	} rule_t;

	typedef struct packed {
		logic [MV_W-1:0]    supply_mv;
		logic               voltage_valid;
		logic [RELAY_W-1:0] relay_states;
		logic [RELAY_W-1:0] override_mask;
		logic [DT_W-1:0]    elapsed_ms;
	} lvrc_in_t;

	typedef struct packed {
		logic [RELAY_W-1:0] new_relay_states;
		logic [RELAY_W-1:0] cut_mask;
		logic [RELAY_W-1:0] restore_mask;
	} lvrc_out_t;

	// word handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic               active;
		logic [MV_W-1:0]    supply_mv;
		logic [RELAY_W-1:0] override_mask;
		logic [DT_W-1:0]    elapsed_ms;
		logic [RELAY_W-1:0] mask;
		logic [RELAY_W-1:0] cuts;
		logic [RELAY_W-1:0] restores;
	} link_t;

	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
			input logic [DT_W-1:0] d);
		logic [TIMER_W:0] s;
		s = {1'b0, t} + (TIMER_W+1)'(d);
		return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
	endfunction

endpackage

/* rtl/lvrc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrc_cell: one rule of the cutoff chain
// Holds one rule with its cut and restore timers, applies it to the word
// passing through and hands the word to the next cell.
// ----------------------------------------------------------------------------
module lvrc_cell import lvrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rule_we,
	input  logic [CFG_W-1:0]  rule_data,
	input  logic              visit,
	input  link_t             link_i,
	input  logic              drain,
	output link_t             link_o
);

	rule_t              rule_q;
	logic               cut_armed_q, rest_armed_q;
	logic [TIMER_W-1:0] cut_ms_q, rest_ms_q;
	link_t              link_q;

	logic               cut_armed_d, rest_armed_d;
	logic [TIMER_W-1:0] cut_ms_d, rest_ms_d;
	link_t              link_d;
	logic [RELAY_W-1:0] bit_sel;
	logic [RELAY_IDX_W-1:0] bit_idx;
	logic               on, low, high;

	always_comb begin
		cut_ms_d     = cut_armed_q  ? sat_add(cut_ms_q, link_i.elapsed_ms)  : cut_ms_q;
		rest_ms_d    = rest_armed_q ? sat_add(rest_ms_q, link_i.elapsed_ms) : rest_ms_q;
		cut_armed_d  = cut_armed_q;
		rest_armed_d = rest_armed_q;
		link_d       = link_i;
		bit_idx      = RELAY_IDX_W'(rule_q.relay_num - NUM_W'(1));
		bit_sel      = RELAY_W'(1) << bit_idx;
		on           = (link_i.mask & bit_sel) != '0;
		low          = on && (link_i.supply_mv < rule_q.cut_mv);
		high         = !on && (rule_q.restore_mv > rule_q.cut_mv)
			&& (link_i.supply_mv >= rule_q.restore_mv);
		if (link_i.active && visit) begin
			if (rule_q.relay_num == '0 || rule_q.relay_num > NUM_W'(RELAY_COUNT)) begin
				cut_armed_d  = 1'b0;
				rest_armed_d = 1'b0;
			end else if ((link_i.override_mask & bit_sel) != '0) begin
				cut_armed_d = 1'b0;
			end else begin
				if (low) begin
					if (!cut_armed_q)
						cut_ms_d = '0;
					if (cut_ms_d >= rule_q.confirm_ms) begin
						link_d.mask = link_d.mask & ~bit_sel;
						link_d.cuts = link_d.cuts | bit_sel;
						cut_armed_d = 1'b0;
					end else begin
						cut_armed_d = 1'b1;
					end
				end else begin
					cut_armed_d = 1'b0;
				end
				if (high) begin
					if (!rest_armed_q)
						rest_ms_d = '0;
					if (rest_ms_d >= rule_q.confirm_ms) begin
						link_d.mask     = link_d.mask | bit_sel;
						link_d.restores = link_d.restores | bit_sel;
						rest_armed_d    = 1'b0;
					end else begin
						rest_armed_d = 1'b1;
					end
				end else begin
					rest_armed_d = 1'b0;
				end
			end
		end
	end

	// word is loaded as the token passes, last cell holds it until drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q       <= '0;
			cut_armed_q  <= 1'b0;
			rest_armed_q <= 1'b0;
			cut_ms_q     <= '0;
			rest_ms_q    <= '0;
			link_q       <= '0;
		end else begin
			if (rule_we)
				rule_q <= rule_t'(rule_data[RULE_W-1:0]);
			if (link_i.vld) begin
				cut_armed_q  <= cut_armed_d;
				rest_armed_q <= rest_armed_d;
				cut_ms_q     <= cut_ms_d;
				rest_ms_q    <= rest_ms_d;
				link_q       <= link_d;
			end else if (drain) begin
				link_q.vld <= 1'b0;
			end
		end
	end

	assign link_o = link_q;

endmodule

/* rtl/low_voltage_relay_cutoff_unit.sv */
`timescale 1ns / 1ps
// Result is valid once the word has passed the registered cells, one cell per rule.
// One word in flight; the next is accepted in the cycle the result is taken.
// Reset clears the enable, all rules, armed flags, timers and the handshake state.
// ----------------------------------------------------------------------------
// low_voltage_relay_cutoff_unit: low-voltage relay disconnect with hysteresis
// A chain of rule cells passes the relay mask along, one rule per cycle.
// ----------------------------------------------------------------------------
module low_voltage_relay_cutoff_unit import lvrc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  lvrc_in_t             sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output lvrc_out_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic  enable_q;
	logic  busy_q;
	logic  sample_take, result_take;
	link_t link [SLOTS+1];

	assign result_take  = result_valid && !result_stall;
	assign sample_stall = busy_q && !result_take;
	assign sample_take  = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_ENABLE)
				enable_q <= cfg_data[0];
			if (sample_take)
				busy_q <= 1'b1;
			else if (result_take)
				busy_q <= 1'b0;
		end
	end

	always_comb begin
		link[0].vld           = sample_take;
		link[0].active        = enable_q && sample.voltage_valid;
		link[0].supply_mv     = sample.supply_mv;
		link[0].override_mask = sample.override_mask;
		link[0].elapsed_ms    = sample.elapsed_ms;
		link[0].mask          = sample.relay_states;
		link[0].cuts          = '0;
		link[0].restores      = '0;
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		lvrc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.rule_we   (cfg_we && cfg_index == REG_RULE0 + CFG_IDX_W'(g)),
			.rule_data (cfg_data),
			.visit     (g < RULE_COUNT),
			.link_i    (link[g]),
			.drain     ((g == SLOTS - 1) ? !result_stall : 1'b1),
			.link_o    (link[g+1])
		);
	end

	assign result_valid            = link[SLOTS].vld;
	assign result.new_relay_states = link[SLOTS].mask;
	assign result.cut_mask         = link[SLOTS].cuts;
	assign result.restore_mask     = link[SLOTS].restores;

endmodule
